[hdl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// One 60 degree sector in 1/64 degree units: 256 * 15
	localparam int unsigned SECTOR_UNITS = 3840;
	localparam int unsigned ONE_Q15      = 32768;

	// Weight for a channel at full scale: ONE_Q15 * SECTOR_UNITS (27 bits)
	localparam int unsigned WEIGHT_FULL  = ONE_Q15 * SECTOR_UNITS;

	// floor(h / 15) for h < 128 as (h * 137) >> 11
	localparam int unsigned RECIP15_MUL   = 137;
	localparam int unsigned RECIP15_SHIFT = 11;

	// 255 / 3840 = 17 / 256, so a channel is (v * w * 17) >> 38
	localparam int unsigned CHAN_SHIFT = 38;

	// Widths
	localparam int unsigned HUE_W    = 15;
	localparam int unsigned Q15_W    = 16;
	localparam int unsigned SECT_W   = 4;
	localparam int unsigned REM_W    = 12;
	localparam int unsigned WEIGHT_W = 27;
	localparam int unsigned PROD_W   = Q15_W + WEIGHT_W;
	localparam int unsigned CHAN_W   = 8;

	// Sector codes; anything from SECTOR_MAGENTA up maps as the last sector
	localparam logic [SECT_W-1:0] SECTOR_RED     = 4'd0;
	localparam logic [SECT_W-1:0] SECTOR_YELLOW  = 4'd1;
	localparam logic [SECT_W-1:0] SECTOR_GREEN   = 4'd2;
	localparam logic [SECT_W-1:0] SECTOR_CYAN    = 4'd3;
	localparam logic [SECT_W-1:0] SECTOR_BLUE    = 4'd4;
	localparam logic [SECT_W-1:0] SECTOR_MAGENTA = 4'd5;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [Q15_W-1:0] saturation;
		logic [Q15_W-1:0] brightness_value;
	} hsv_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// Sector split result, clamped saturation and value
	typedef struct packed {
		logic [SECT_W-1:0] sector;
		logic [REM_W-1:0]  rem;
		logic [REM_W-1:0]  rem_comp;
		logic [Q15_W-1:0]  sat;
		logic [Q15_W-1:0]  val;
	} sect_t;

	// Unscaled channel products v * w
	typedef struct packed {
		logic [SECT_W-1:0] sector;
		logic [PROD_W-1:0] prod_v;
		logic [PROD_W-1:0] prod_p;
		logic [PROD_W-1:0] prod_q;
		logic [PROD_W-1:0] prod_t;
	} chan_t;

	// Final scale of one channel: floor(prod * 17 / 2^38)
	function automatic logic [CHAN_W-1:0] scale_chan(input logic [PROD_W-1:0] prod);
		logic [PROD_W+3:0] x17;
		x17 = {prod, 4'b0000} + {4'b0000, prod};
		return x17[CHAN_SHIFT+CHAN_W-1:CHAN_SHIFT];
	endfunction

endpackage

[hdl/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed point HSV to 8-bit RGB conversion, five stage pipeline.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge where start is high; busy never rises,
// so one pixel per cycle is sustained. Each result shows on rgb for one cycle
// with done high, after passing the stages in order: stage 1 clamps and finds
// the sector, stage 2 the remainder, stage 3 the channel weights, stage 4 the
// value products, stage 5 scales by 255 and routes by sector. Results come in
// input order and must be captured in the cycle done is high.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  hsv_t hsv,
	output logic done,
	output rgb_t rgb
);

	logic  sect_valid, chan_valid;
	sect_t sect;
	chan_t chan;
	logic  done_s5;
	rgb_t  rgb_s5;

	logic [CHAN_W-1:0] cv, cp, cq, ct;
	rgb_t              rgb_sel;

	hsv2rgb_sector u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_hsv    (hsv),
		.out_valid (sect_valid),
		.out_sect  (sect)
	);

	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sect_valid),
		.in_sect   (sect),
		.out_valid (chan_valid),
		.out_chan  (chan)
	);

	// Scale by 255 and apply the six-sector rule
	always_comb begin
		cv = scale_chan(chan.prod_v);
		cp = scale_chan(chan.prod_p);
		cq = scale_chan(chan.prod_q);
		ct = scale_chan(chan.prod_t);
		unique case (chan.sector)
			SECTOR_RED:    rgb_sel = '{red: cv, green: ct, blue: cp};
			SECTOR_YELLOW: rgb_sel = '{red: cq, green: cv, blue: cp};
			SECTOR_GREEN:  rgb_sel = '{red: cp, green: cv, blue: ct};
			SECTOR_CYAN:   rgb_sel = '{red: cp, green: cq, blue: cv};
			SECTOR_BLUE:   rgb_sel = '{red: ct, green: cp, blue: cv};
			default:       rgb_sel = '{red: cv, green: cp, blue: cq};
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= chan_valid;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s5 <= rgb_sel;
	end

	assign busy = 1'b0;
	assign done = done_s5;
	assign rgb  = rgb_s5;

endmodule

[hdl/hsv2rgb_sector.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Stages 1 and 2: clamp inputs, split hue into sector and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_sector import hsv2rgb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  hsv_t  in_hsv,
	output logic  out_valid,
	output sect_t out_sect
);

	logic              valid_s1, valid_s2;
	logic [HUE_W-1:0]  hue_s1;
	logic [SECT_W-1:0] sector_s1;
	logic [Q15_W-1:0]  sat_s1, val_s1;
	sect_t             sect_s2;

	logic [Q15_W-1:0]  sat_clamp, val_clamp;
	logic [14:0]       recip_prod;
	logic [15:0]       sector_base;
	logic [HUE_W-1:0]  rem_full;
	logic [REM_W-1:0]  rem;

	// Saturate Q1.15 fields at 1.0; sector = floor((hue >> 8) / 15)
	always_comb begin
		sat_clamp  = (in_hsv.saturation > Q15_W'(ONE_Q15)) ? Q15_W'(ONE_Q15)
		                                                   : in_hsv.saturation;
		val_clamp  = (in_hsv.brightness_value > Q15_W'(ONE_Q15)) ? Q15_W'(ONE_Q15)
		                                                         : in_hsv.brightness_value;
		recip_prod = 15'(in_hsv.hue[HUE_W-1:8]) * 15'(RECIP15_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		hue_s1    <= in_hsv.hue;
		sector_s1 <= SECT_W'(recip_prod >> RECIP15_SHIFT);
		sat_s1    <= sat_clamp;
		val_s1    <= val_clamp;
	end

	// Remainder within the sector and its complement
	always_comb begin
		sector_base = 16'(sector_s1) * 16'(SECTOR_UNITS);
		rem_full    = hue_s1 - sector_base[HUE_W-1:0];
		rem         = rem_full[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sect_s2.sector   <= sector_s1;
		sect_s2.rem      <= rem;
		sect_s2.rem_comp <= REM_W'(SECTOR_UNITS) - rem;
		sect_s2.sat      <= sat_s1;
		sect_s2.val      <= val_s1;
	end

	assign out_valid = valid_s2;
	assign out_sect  = sect_s2;

endmodule

[hdl/hsv2rgb_scale.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Stages 3 and 4: channel weights w = 1 - s*x, then products v * w.
// ----------------------------------------------------------------------------
module hsv2rgb_scale import hsv2rgb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  sect_t in_sect,
	output logic  out_valid,
	output chan_t out_chan
);

	logic                valid_s3, valid_s4;
	logic [SECT_W-1:0]   sector_s3;
	logic [Q15_W-1:0]    val_s3;
	logic [WEIGHT_W-1:0] w_p_s3, w_q_s3, w_t_s3;
	chan_t               chan_s4;

	logic [WEIGHT_W-1:0] sx_p, sx_q, sx_t;

	// s * x terms; each stays at or below ONE_Q15 * SECTOR_UNITS
	always_comb begin
		sx_p = WEIGHT_W'(in_sect.sat) * WEIGHT_W'(SECTOR_UNITS);
		sx_q = WEIGHT_W'(in_sect.sat) * WEIGHT_W'(in_sect.rem);
		sx_t = WEIGHT_W'(in_sect.sat) * WEIGHT_W'(in_sect.rem_comp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sector_s3 <= in_sect.sector;
		val_s3    <= in_sect.val;
		w_p_s3    <= WEIGHT_W'(WEIGHT_FULL) - sx_p;
		w_q_s3    <= WEIGHT_W'(WEIGHT_FULL) - sx_q;
		w_t_s3    <= WEIGHT_W'(WEIGHT_FULL) - sx_t;
	end

	// One 16x27 product per channel candidate
	always_ff @(posedge clk) begin
		chan_s4.sector <= sector_s3;
		chan_s4.prod_v <= PROD_W'(val_s3) * PROD_W'(WEIGHT_FULL);
		chan_s4.prod_p <= PROD_W'(val_s3) * PROD_W'(w_p_s3);
		chan_s4.prod_q <= PROD_W'(val_s3) * PROD_W'(w_q_s3);
		chan_s4.prod_t <= PROD_W'(val_s3) * PROD_W'(w_t_s3);
	end

	assign out_valid = valid_s4;
	assign out_chan  = chan_s4;

endmodule

[hdl/hsv2rgb_checker.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker import hsv2rgb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input hsv_t hsv,
	input logic done,
	input rgb_t rgb
);

	// Pipeline never stalls the sender
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// Every result traces back to an earlier matching transfer on start
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without matching transfer");

	// Zero saturation gives grey
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && hsv.saturation == '0, 5)
		|-> rgb.red == rgb.green && rgb.green == rgb.blue)
		else $error("zero saturation not grey");

	// Zero value gives black
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && hsv.brightness_value == '0, 5)
		|-> rgb.red == '0 && rgb.green == '0 && rgb.blue == '0)
		else $error("zero value not black");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.hsv    (hsv),
	.done   (done),
	.rgb    (rgb)
);
